// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the receiver modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RCFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define RCFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rcfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcfr_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int BYTE_W          = 8;
  localparam int TIME_W          = 32;
  localparam int LEN_W           = BYTE_W + 1;

  localparam int FIRST_GUESS_LEN = 5;
  localparam int LEN_KNOWN_POS   = 3;
  localparam int POS_ADDR        = 0;
  localparam int POS_LEN         = 1;
  localparam int POS_TYPE        = 2;
  localparam int CRC_FIRST_POS   = POS_TYPE;

  localparam int NUM_CHANNELS    = 16;
  localparam int CH_BITS         = 11;
  localparam int CH_IDX_W        = $clog2(NUM_CHANNELS);
  localparam int CH_FIRST_BYTE   = 3;
  localparam int READ_BITS       = 2 * BYTE_W;
  localparam int CH_READS        = (NUM_CHANNELS * CH_BITS + READ_BITS - 1) / READ_BITS;
  localparam int BIDX_W          = $clog2(CH_FIRST_BYTE + 2 * CH_READS + 1);
  localparam int CMP_W           = (POS_W > BIDX_W) ? POS_W : BIDX_W;

  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [TIME_W-1:0] RST_TIMEOUT = '0;
  localparam logic [BYTE_W-1:0] RST_CH_TYPE = 8'd22;
  localparam logic [BYTE_W-1:0] RST_TARGET  = 8'd200;
  localparam logic [BYTE_W-1:0] RST_POLY    = 8'd213;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TIMEOUT = 2'd0,
    CFG_CHANNEL_TYPE  = 2'd1,
    CFG_TARGET_ADDR   = 2'd2,
    CFG_CRC_POLY      = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                    frame_end;
    logic                    crc_good;
    logic                    channels_valid;
    logic [CH_IDX_W-1:0]     channel_index;
    logic [CH_BITS-1:0]      channel_value;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] full;
  } unpack_ctrl_t;

  typedef struct packed {
    logic busy;
    logic item_valid;
  } unpack_stat_t;

  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data,
                                                    input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = (c << 1) ^ poly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rcfr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rcfr_in_if;
  logic                          valid;
  logic                          ready;
  logic [rcfr_pkg::BYTE_W-1:0]   rx_byte;
  logic [rcfr_pkg::TIME_W-1:0]   arrival_us;

  modport source (output valid, output rx_byte, output arrival_us, input ready);
  modport sink (input valid, input rx_byte, input arrival_us, output ready);
endinterface

interface rcfr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          frame_end;
  logic                          crc_good;
  logic                          channels_valid;
  logic [rcfr_pkg::CH_IDX_W-1:0] channel_index;
  logic [rcfr_pkg::CH_BITS-1:0]  channel_value;
  logic                          last;

  modport source (output valid, output frame_end, output crc_good, output channels_valid,
                  output channel_index, output channel_value, output last, input ready);
  modport sink (input valid, input frame_end, input crc_good, input channels_valid,
                input channel_index, input channel_value, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/rc_link_frame_receiver.sv =====
// Link frame receiver.
// in_ch carries one received byte with its microsecond arrival time per request;
// out_ch carries result requests. Both use valid/ready, moving a request at a
// rising edge where both are high. The cfg_we/cfg_index/cfg_data port writes the
// timeout, channel frame type, target address and CRC polynomial, one per edge.
// Bytes are taken one per cycle while in_ch.ready is high. A byte that completes
// no frame gives no result. A completed frame that is not a good channel frame
// gives one registered result. A good channel frame gives sixteen channel results:
// the unpacker reads two stored bytes per cycle from the frame memory while its
// bit buffer has room, and the channels follow one per cycle while out_ch takes
// them; in_ch is held off while those sixteen results are produced. An output
// register plus one skid entry let bytes keep flowing while a result waits; when
// out_ch stalls, in_ch stops only once the skid entry is full. Reset clears the
// position, start time, CRC and registers to their defaults; the frame memory is
// not cleared, since every byte read was written first.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rc_link_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  rcfr_in_if.sink                        in_ch,
  rcfr_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rcfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcfr_pkg::*;

  logic [TIME_W-1:0] timeout;
  logic [BYTE_W-1:0] chan_type;
  logic [BYTE_W-1:0] target;
  logic [BYTE_W-1:0] poly;

  logic [POS_W-1:0]  byte_position;
  logic [TIME_W-1:0] start_us;
  logic [BYTE_W-1:0] running_crc;
  logic [BYTE_W-1:0] addr_reg;
  logic [BYTE_W-1:0] len_reg;
  logic [BYTE_W-1:0] type_reg;

  logic              out_valid;
  result_t           out_q;
  logic              pend_valid;
  result_t           pend_q;

  logic              accept;
  logic [TIME_W-1:0] elapsed;
  logic              timed_out;
  logic [POS_W-1:0]  pos_eff;
  logic [POS_W-1:0]  pos_next;
  logic              first;
  logic [BYTE_W-1:0] crc_base;
  logic [BYTE_W-1:0] crc_step;
  logic [BYTE_W-1:0] crc_new;
  logic [LEN_W-1:0]  len_plus;
  logic [POS_W-1:0]  full;
  logic              store_en;
  logic              complete;
  logic              good;
  logic              chan;
  logic              single_new;
  result_t           single_res;
  logic              out_free;
  logic              emit_ok;
  logic              burst_take;

  unpack_ctrl_t      uctrl;
  unpack_stat_t      ustat;
  result_t           uitem;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [BYTE_W-1:0] rdata_a;
  logic [BYTE_W-1:0] rdata_b;

  always_comb begin
    in_ch.ready = !ustat.busy && !pend_valid;
    accept    = in_ch.valid && in_ch.ready;
    elapsed   = in_ch.arrival_us - start_us;
    timed_out = elapsed > timeout;
    pos_eff   = timed_out ? '0 : byte_position;
    first     = (pos_eff == '0);
    crc_base  = first ? '0 : running_crc;
    len_plus  = LEN_W'(len_reg) + LEN_W'(2);
    if (pos_eff < POS_W'(LEN_KNOWN_POS)) begin
      full = POS_W'(FIRST_GUESS_LEN);
    end else if (len_plus > LEN_W'(MAX_FRAME_BYTES)) begin
      full = POS_W'(MAX_FRAME_BYTES);
    end else begin
      full = len_plus[POS_W-1:0];
    end
    store_en  = pos_eff < full;
    pos_next  = pos_eff + POS_W'(1);
    complete  = store_en && (pos_next == full);
    crc_step  = crc8_update(crc_base, in_ch.rx_byte, poly);
    crc_new   = ((pos_eff >= POS_W'(CRC_FIRST_POS)) && !complete) ? crc_step : crc_base;
    good      = (crc_base == in_ch.rx_byte);
    chan      = good && (type_reg == chan_type) && (addr_reg == target);

    single_new                = accept && complete && !chan;
    single_res.frame_end      = 1'b1;
    single_res.crc_good       = good;
    single_res.channels_valid = 1'b0;
    single_res.channel_index  = '0;
    single_res.channel_value  = '0;
    single_res.last           = 1'b1;

    uctrl.start = accept && complete && chan;
    uctrl.full  = full;

    out_free   = !out_valid || out_ch.ready;
    emit_ok    = out_free && !pend_valid;
    burst_take = ustat.item_valid && emit_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout   <= RST_TIMEOUT;
      chan_type <= RST_CH_TYPE;
      target    <= RST_TARGET;
      poly      <= RST_POLY;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAME_TIMEOUT: timeout   <= cfg_data[TIME_W-1:0];
        CFG_CHANNEL_TYPE:  chan_type <= cfg_data[BYTE_W-1:0];
        CFG_TARGET_ADDR:   target    <= cfg_data[BYTE_W-1:0];
        CFG_CRC_POLY:      poly      <= cfg_data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      start_us      <= '0;
      running_crc   <= '0;
    end else if (accept) begin
      if (first) begin
        start_us <= in_ch.arrival_us;
      end
      if (store_en) begin
        if (complete) begin
          byte_position <= '0;
          running_crc   <= '0;
        end else begin
          byte_position <= pos_next;
          running_crc   <= crc_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      if (pos_eff == POS_W'(POS_ADDR)) begin
        addr_reg <= in_ch.rx_byte;
      end
      if (pos_eff == POS_W'(POS_LEN)) begin
        len_reg <= in_ch.rx_byte;
      end
      if (pos_eff == POS_W'(POS_TYPE)) begin
        type_reg <= in_ch.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid) begin
        if (out_free) begin
          out_valid  <= 1'b1;
          out_q      <= pend_q;
          pend_valid <= 1'b0;
        end
      end else if (single_new) begin
        if (out_free) begin
          out_valid <= 1'b1;
          out_q     <= single_res;
        end else begin
          pend_valid <= 1'b1;
          pend_q     <= single_res;
        end
      end else if (burst_take) begin
        out_valid <= 1'b1;
        out_q     <= uitem;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  rcfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_frame_store (
    .clk     (clk),
    .we      (accept && store_en),
    .waddr   (pos_eff[ADDR_W-1:0]),
    .wdata   (in_ch.rx_byte),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  rcfr_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (uctrl),
    .emit_ok (emit_ok),
    .byte_a  (rdata_a),
    .byte_b  (rdata_b),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .stat    (ustat),
    .item    (uitem)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.frame_end      = out_q.frame_end;
  assign out_ch.crc_good       = out_q.crc_good;
  assign out_ch.channels_valid = out_q.channels_valid;
  assign out_ch.channel_index  = out_q.channel_index;
  assign out_ch.channel_value  = out_q.channel_value;
  assign out_ch.last           = out_q.last;

  `RCFR_ASSERT_IMP(a_skid_behind_out, pend_valid, out_valid, "skid entry ahead of output")
  `RCFR_ASSERT_NXT(a_burst_starts, uctrl.start, ustat.busy, "channel burst did not start")
  `RCFR_ASSERT_IMP(a_burst_skid_empty, ustat.busy, !pend_valid, "skid entry during burst")

endmodule

`default_nettype wire

// ===== hdl/rcfr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== hdl/rcfr_unpack.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rcfr_unpack (
  input  logic                         clk,
  input  logic                         rst,
  input  rcfr_pkg::unpack_ctrl_t       ctrl,
  input  logic                         emit_ok,
  input  logic [rcfr_pkg::BYTE_W-1:0]  byte_a,
  input  logic [rcfr_pkg::BYTE_W-1:0]  byte_b,
  output logic [rcfr_pkg::ADDR_W-1:0]  raddr_a,
  output logic [rcfr_pkg::ADDR_W-1:0]  raddr_b,
  output rcfr_pkg::unpack_stat_t       stat,
  output rcfr_pkg::result_t            item
);
  import rcfr_pkg::*;

  localparam int ACC_W       = 48;
  localparam int CNT_W       = $clog2(ACC_W + 1);
  localparam int ISSUE_LIMIT = ACC_W - READ_BITS;
  localparam int J_W         = $clog2(CH_READS + 1);

  logic                 busy;
  logic [J_W-1:0]       rd_j;
  logic                 rd_pend;
  logic [1:0]           rd_mask;
  logic [ACC_W-1:0]     acc;
  logic [CNT_W-1:0]     cnt;
  logic [CH_IDX_W-1:0]  ch_k;
  logic [POS_W-1:0]     full_q;

  logic [CMP_W-1:0]     idx_a;
  logic [CMP_W-1:0]     idx_b;
  logic                 item_valid;
  logic                 cons;
  logic                 issue;
  logic                 last_ch;
  logic [CNT_W-1:0]     cnt_after;
  logic [CNT_W-1:0]     cnt_next;
  logic [READ_BITS-1:0] arr_bits;
  logic [ACC_W-1:0]     acc_shift;
  logic [ACC_W-1:0]     acc_next;

  always_comb begin
    idx_a      = CMP_W'(CH_FIRST_BYTE) + (CMP_W'(rd_j) << 1);
    idx_b      = idx_a + CMP_W'(1);
    raddr_a    = idx_a[ADDR_W-1:0];
    raddr_b    = idx_b[ADDR_W-1:0];
    item_valid = busy && (cnt >= CNT_W'(CH_BITS));
    cons       = item_valid && emit_ok;
    last_ch    = (ch_k == CH_IDX_W'(NUM_CHANNELS - 1));
    cnt_after  = cons ? (cnt - CNT_W'(CH_BITS)) : cnt;
    arr_bits   = '0;
    if (rd_pend) begin
      arr_bits = {(rd_mask[1] ? byte_b : '0), (rd_mask[0] ? byte_a : '0)};
    end
    acc_shift  = cons ? (acc >> CH_BITS) : acc;
    acc_next   = acc_shift | (ACC_W'(arr_bits) << cnt_after);
    cnt_next   = cnt_after + (rd_pend ? CNT_W'(READ_BITS) : '0);
    issue      = busy && (rd_j < J_W'(CH_READS)) && (cnt_next <= CNT_W'(ISSUE_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      rd_pend <= 1'b0;
      rd_j    <= '0;
      cnt     <= '0;
      ch_k    <= '0;
    end else if (ctrl.start) begin
      busy    <= 1'b1;
      rd_pend <= 1'b0;
      rd_j    <= '0;
      cnt     <= '0;
      ch_k    <= '0;
    end else begin
      rd_pend <= issue;
      cnt     <= cnt_next;
      if (issue) begin
        rd_j <= rd_j + J_W'(1);
      end
      if (cons) begin
        ch_k <= ch_k + CH_IDX_W'(1);
        if (last_ch) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc    <= '0;
      full_q <= ctrl.full;
    end else begin
      acc <= acc_next;
    end
    rd_mask <= {(CMP_W'(full_q) > idx_b), (CMP_W'(full_q) > idx_a)};
  end

  always_comb begin
    stat.busy           = busy;
    stat.item_valid     = item_valid;
    item.frame_end      = 1'b1;
    item.crc_good       = 1'b1;
    item.channels_valid = 1'b1;
    item.channel_index  = ch_k;
    item.channel_value  = acc[CH_BITS-1:0];
    item.last           = last_ch;
  end

  `RCFR_ASSERT_IMP(a_cnt_fits, busy, cnt <= CNT_W'(ACC_W), "bit buffer overflow")
  `RCFR_ASSERT_IMP(a_room_for_read, rd_pend, cnt <= CNT_W'(ISSUE_LIMIT), "read landed without room")
  `RCFR_ASSERT_IMP(a_no_restart, ctrl.start, !busy, "unpack started while busy")

endmodule

`default_nettype wire
